>>> hdl/assert_macros.svh
// assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off while in reset
`define ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off while in reset
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hdl/efwt_pkg.sv
// types, codes and sizes shared by the forwarding table files
package efwt_pkg;

	localparam int TABLE_DEPTH = 8;
	localparam int ADDR_W      = 16;
	localparam int HOP_W       = 8;
	localparam int CNT_W       = 4;
	localparam int APB_DW      = 32;
	localparam int APB_AW      = 3;

	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
	localparam logic [CNT_W-1:0] OCC_MAX =
		(TABLE_DEPTH > 15) ? CNT_MAX : CNT_W'(TABLE_DEPTH);

	localparam logic [APB_AW-1:0] ADDR_DEFAULT_HOP = APB_AW'(0);

	typedef enum logic {
		OP_INSERT = 1'b0,
		OP_LOOKUP = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_FULL       = 2'd1,
		ST_MISALIGNED = 2'd2
	} status_t;

	// item travelling down the cell chain with its running result
	typedef struct packed {
		logic              valid;
		op_t               op;
		logic [ADDR_W-1:0] addr;
		logic [HOP_W-1:0]  hop;
		logic              picked;
		status_t           status;
		logic              found;
		logic [HOP_W-1:0]  hop_acc;
		logic [CNT_W-1:0]  count;
	} token_t;

endpackage

>>> hdl/efwt_cell.sv
// one table slot: holds an address and hop pair and updates the passing item
module efwt_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  efwt_pkg::token_t tok_in,
	output efwt_pkg::token_t tok_out
);

	logic [efwt_pkg::ADDR_W-1:0] slot_address_q;
	logic [efwt_pkg::HOP_W-1:0]  slot_hop_q;
	efwt_pkg::token_t            tok_q;
	efwt_pkg::token_t            tok_c;
	logic                        wr_c;
	logic                        slot_free_c;
	logic                        slot_half_c;
	logic [efwt_pkg::HOP_W-1:0]  hop_after_c;

	always_comb begin
		slot_free_c = (slot_hop_q == '0) || (slot_address_q == '0);
		slot_half_c = (slot_hop_q == '0) != (slot_address_q == '0);
		tok_c       = tok_in;
		wr_c        = 1'b0;
		if (tok_in.valid) begin
			unique case (tok_in.op)
				efwt_pkg::OP_INSERT: begin
					// first free slot claims the insert
					if (!tok_in.picked && slot_free_c) begin
						tok_c.picked = 1'b1;
						if (slot_half_c) begin
							tok_c.status = efwt_pkg::ST_MISALIGNED;
						end else begin
							wr_c = 1'b1;
						end
					end
				end
				efwt_pkg::OP_LOOKUP: begin
					// later slots overwrite, so the last match wins
					if (slot_address_q == tok_in.addr) begin
						tok_c.found   = 1'b1;
						tok_c.hop_acc = slot_hop_q;
					end
				end
			endcase
		end
		hop_after_c = wr_c ? tok_in.hop : slot_hop_q;
		if (hop_after_c != '0 && tok_in.count != efwt_pkg::CNT_MAX) begin
			tok_c.count = tok_in.count + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_address_q <= '0;
			slot_hop_q     <= '0;
			tok_q          <= '0;
		end else begin
			if (wr_c) begin
				slot_address_q <= tok_in.addr;
				slot_hop_q     <= tok_in.hop;
			end
			tok_q <= tok_c;
		end
	end

	assign tok_out = tok_q;

endmodule

>>> hdl/exact_match_forwarding_table_top.sv
// forwarding table top level: cell chain, result registers and apb register
// path: the item walks the cell chain one slot per cycle, then the pending and output result registers
// only one item is in the chain at a time; the next is taken once the result moves
//   to the output register, so a stalled result holds off the next item
// reset: arst_n (asynchronous, active low) clears every slot, the default hop
//   and all handshake state
module exact_match_forwarding_table_top (
	input  logic                          clk,
	input  logic                          arst_n,
	// input channel
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          operation,
	input  logic [efwt_pkg::ADDR_W-1:0]   dest_address,
	input  logic [efwt_pkg::HOP_W-1:0]    hop_in,
	// result channel
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [1:0]                    status,
	output logic [efwt_pkg::HOP_W-1:0]    hop_out,
	output logic [efwt_pkg::CNT_W-1:0]    occupied_count,
	// configuration port
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [efwt_pkg::APB_AW-1:0]   paddr,
	input  logic [efwt_pkg::APB_DW-1:0]   pwdata,
	output logic [efwt_pkg::APB_DW-1:0]   prdata,
	output logic                          pready
);

	// chain taps: tok_c[0] is the entering item, tok_c[TABLE_DEPTH] leaves the last cell
	efwt_pkg::token_t tok_c [efwt_pkg::TABLE_DEPTH+1];

	logic                          busy_q;
	logic [efwt_pkg::HOP_W-1:0]    default_hop_q;

	// finished result parked until the output register is free
	logic                          pend_valid_q;
	efwt_pkg::status_t             pend_status_q;
	logic [efwt_pkg::HOP_W-1:0]    pend_hop_q;
	logic [efwt_pkg::CNT_W-1:0]    pend_count_q;

	logic                          out_valid_q;
	efwt_pkg::status_t             out_status_q;
	logic [efwt_pkg::HOP_W-1:0]    out_hop_q;
	logic [efwt_pkg::CNT_W-1:0]    out_count_q;

	logic                          accept_c;
	logic                          move_c;
	logic                          cfg_wr_c;
	efwt_pkg::token_t              last_c;
	efwt_pkg::status_t             fin_status_c;
	logic [efwt_pkg::HOP_W-1:0]    fin_hop_c;

	// only one item walks the chain at a time
	assign in_ready = !busy_q;
	assign accept_c = in_valid && in_ready;

	always_comb begin
		tok_c[0]         = '0;
		tok_c[0].valid   = accept_c;
		tok_c[0].op      = efwt_pkg::op_t'(operation);
		tok_c[0].addr    = dest_address;
		tok_c[0].hop     = hop_in;
		tok_c[0].status  = efwt_pkg::ST_OK;
	end

	for (genvar g = 0; g < efwt_pkg::TABLE_DEPTH; g++) begin : g_cell
		efwt_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.tok_in  (tok_c[g]),
			.tok_out (tok_c[g+1])
		);
	end

	// close out the item leaving the chain
	always_comb begin
		last_c       = tok_c[efwt_pkg::TABLE_DEPTH];
		fin_status_c = last_c.status;
		fin_hop_c    = '0;
		unique case (last_c.op)
			efwt_pkg::OP_INSERT: begin
				// no slot took the insert: every slot is fully set
				if (!last_c.picked) begin
					fin_status_c = efwt_pkg::ST_FULL;
				end
			end
			efwt_pkg::OP_LOOKUP: begin
				// default route on a miss
				fin_hop_c = last_c.found ? last_c.hop_acc : default_hop_q;
			end
		endcase
	end

	assign move_c = pend_valid_q && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q        <= 1'b0;
			pend_valid_q  <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			if (accept_c) begin
				busy_q <= 1'b1;
			end else if (move_c) begin
				busy_q <= 1'b0;
			end
			if (last_c.valid) begin
				pend_valid_q <= 1'b1;
			end else if (move_c) begin
				pend_valid_q <= 1'b0;
			end
			if (move_c) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result payload, no reset needed
	always_ff @(posedge clk) begin
		if (last_c.valid) begin
			pend_status_q <= fin_status_c;
			pend_hop_q    <= fin_hop_c;
			pend_count_q  <= last_c.count;
		end
		if (move_c) begin
			out_status_q <= pend_status_q;
			out_hop_q    <= pend_hop_q;
			out_count_q  <= pend_count_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = out_status_q;
	assign hop_out        = out_hop_q;
	assign occupied_count = out_count_q;

	// default route register, single entry at byte address zero
	assign pready   = 1'b1;
	assign cfg_wr_c = psel && penable && pwrite && pready && (paddr == efwt_pkg::ADDR_DEFAULT_HOP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			default_hop_q <= '0;
		end else if (cfg_wr_c) begin
			default_hop_q <= pwdata[efwt_pkg::HOP_W-1:0];
		end
	end

	always_comb begin
		if (paddr == efwt_pkg::ADDR_DEFAULT_HOP) begin
			prdata = {{(efwt_pkg::APB_DW-efwt_pkg::HOP_W){1'b0}}, default_hop_q};
		end else begin
			prdata = '0;
		end
	end

endmodule

>>> hdl/efwt_checker.sv
// port-level checks for the forwarding table, bound to the top level
`include "assert_macros.svh"

module efwt_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_ready,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic [1:0]                  status,
	input logic [efwt_pkg::HOP_W-1:0]  hop_out,
	input logic [efwt_pkg::CNT_W-1:0]  occupied_count
);

	// a stalled result holds its payload
	`ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(hop_out) && $stable(status) && $stable(occupied_count), "stalled result changed")

	// one item in flight: no accept right after an accept
	`ASSERT_NEXT(a_one_in_flight, in_valid && in_ready, !in_ready, "second item taken while chain busy")

	// insert errors never carry a next hop
	`ASSERT_NOW(a_err_no_hop, out_valid && status != efwt_pkg::ST_OK, hop_out == '0, "error result with nonzero hop")

	// count never exceeds the slot total
	`ASSERT_NOW(a_count_range, out_valid, occupied_count <= efwt_pkg::OCC_MAX, "occupied count out of range")

endmodule

bind exact_match_forwarding_table_top efwt_checker u_efwt_checker (.*);
